@@ hw/rtl/wtps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wtps_pkg
// Shared constants, field widths and controller/datapath handshake types for
// the weekly time program selector.
// ----------------------------------------------------------------------------
package wtps_pkg;

   // Number of program slots in the table (1 to 16).
   localparam int PROGRAM_SLOTS = 16;
   localparam int SLOT_IDX_W    = (PROGRAM_SLOTS > 1) ? $clog2(PROGRAM_SLOTS) : 1;

   // Field widths
   localparam int SLOT_W   = 4;
   localparam int HOUR_W   = 5;
   localparam int MIN_W    = 6;
   localparam int MODE_W   = 4;
   localparam int DAYS_W   = 7;
   localparam int WDAY_W   = 3;
   localparam int ACTIVE_W = 5;
   localparam int KEY_W    = HOUR_W + MIN_W;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 16;

   // Action codes carried on req_tuser
   localparam logic ACTION_WRITE = 1'b1;

   localparam logic [ACTIVE_W-1:0] ACTIVE_NONE  = '1;
   localparam logic [WDAY_W-1:0]   LAST_WEEKDAY = 3'd6;

   typedef struct packed {
      logic [HOUR_W-1:0] start_hour;
      logic [MIN_W-1:0]  start_minute;
      logic [HOUR_W-1:0] end_hour;
      logic [MIN_W-1:0]  end_minute;
      logic [MODE_W-1:0] mode_value;
      logic [DAYS_W-1:0] day_mask;
   } entry_type;

   typedef struct packed {
      logic capture;    // latch the accepted request
      logic scan_step;  // test one slot and advance the scan index
      logic commit;     // update state and load the result register
   } cmd_type;

   typedef struct packed {
      logic is_write;   // latched request is a slot write
      logic scan_hit;   // slot under the scan index matches
      logic scan_last;  // scan index is on the last slot
      logic out_free;   // result register can take a new result
   } status_type;

endpackage
`default_nettype wire

@@ hw/rtl/wtps_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wtps_datapath
// Program table, request latch, slot scan, active program and result register.
// ----------------------------------------------------------------------------
module wtps_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire wtps_pkg::cmd_type              cmd,
   output wtps_pkg::status_type                status,
   input  wire logic                           req_tuser,
   input  wire logic [wtps_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [wtps_pkg::MODE_W-1:0]    csr_wdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [wtps_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import wtps_pkg::*;

   localparam logic [SLOT_W:0]     SLOT_LIMIT = (SLOT_W + 1)'(PROGRAM_SLOTS);
   localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(PROGRAM_SLOTS - 1);

   // Table
   entry_type                  table_ff  [PROGRAM_SLOTS];
   logic [PROGRAM_SLOTS-1:0]   enable_ff;

   // Request latch
   logic                       action_ff;
   logic [SLOT_W-1:0]          slot_ff;
   logic                       wr_enable_ff;
   entry_type                  wr_entry_ff;
   logic [KEY_W-1:0]           now_key_ff;
   logic [WDAY_W-1:0]          now_wd_ff;

   // Scan
   logic [SLOT_IDX_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                       found_ff, found_in;
   logic [SLOT_IDX_W-1:0]      pick_ff, pick_in;
   logic [MODE_W-1:0]          pick_mode_ff, pick_mode_in;

   // Active program and configuration
   logic                       active_valid_ff, active_valid_in;
   logic [SLOT_IDX_W-1:0]      active_idx_ff, active_idx_in;
   logic [MODE_W-1:0]          default_mode_ff, default_mode_in;

   // Result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_changed_ff, rsp_changed_in;
   logic [MODE_W-1:0]          rsp_fan_ff, rsp_fan_in;
   logic [ACTIVE_W-1:0]        rsp_active_ff, rsp_active_in;
   logic                       rsp_werr_ff, rsp_werr_in;

   entry_type                  scan_entry;
   logic [KEY_W-1:0]           start_key, stop_key;
   logic [DAYS_W:0]            day_vec;
   logic [WDAY_W-1:0]          prev_wd;
   logic                       hit;
   logic                       slot_bad;
   logic [SLOT_IDX_W-1:0]      wr_idx;
   logic                       table_we;

   // Window test on the slot under the scan index
   always_comb begin
      scan_entry = table_ff[scan_idx_ff];
      start_key  = {scan_entry.start_hour, scan_entry.start_minute};
      stop_key   = {scan_entry.end_hour, scan_entry.end_minute};
      day_vec    = {1'b0, scan_entry.day_mask};
      prev_wd    = (now_wd_ff == '0) ? LAST_WEEKDAY : now_wd_ff - WDAY_W'(1);
      hit        = 1'b0;
      if (enable_ff[scan_idx_ff] && (now_wd_ff <= LAST_WEEKDAY)) begin
         if (start_key > stop_key) begin
            // window wraps past midnight: early part belongs to the previous day
            if (now_key_ff >= start_key) begin
               hit = day_vec[now_wd_ff];
            end else if (now_key_ff < stop_key) begin
               hit = day_vec[prev_wd];
            end
         end else if ((now_key_ff >= start_key) && (now_key_ff < stop_key)) begin
            hit = day_vec[now_wd_ff];
         end
      end
   end

   assign slot_bad = ({1'b0, slot_ff} >= SLOT_LIMIT);
   assign wr_idx   = slot_ff[SLOT_IDX_W-1:0];
   assign table_we = cmd.commit && (action_ff == ACTION_WRITE) && !slot_bad;

   assign status.is_write  = (action_ff == ACTION_WRITE);
   assign status.scan_hit  = hit;
   assign status.scan_last = (scan_idx_ff == LAST_IDX);
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      scan_idx_in     = scan_idx_ff;
      found_in        = found_ff;
      pick_in         = pick_ff;
      pick_mode_in    = pick_mode_ff;
      active_valid_in = active_valid_ff;
      active_idx_in   = active_idx_ff;
      default_mode_in = default_mode_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_changed_in  = rsp_changed_ff;
      rsp_fan_in      = rsp_fan_ff;
      rsp_active_in   = rsp_active_ff;
      rsp_werr_in     = rsp_werr_ff;

      if (csr_valid) begin
         default_mode_in = csr_wdata;
      end

      if (cmd.capture) begin
         scan_idx_in = '0;
         found_in    = 1'b0;
      end else if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + SLOT_IDX_W'(1);
         if (hit) begin
            found_in     = 1'b1;
            pick_in      = scan_idx_ff;
            pick_mode_in = scan_entry.mode_value;
         end
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.commit) begin
         rsp_valid_in   = 1'b1;
         rsp_changed_in = 1'b0;
         rsp_fan_in     = '0;
         rsp_werr_in    = 1'b0;
         if (action_ff == ACTION_WRITE) begin
            rsp_werr_in = slot_bad;
            // rewriting the active slot drops the active program
            if (!slot_bad && active_valid_ff && (active_idx_ff == wr_idx)) begin
               active_valid_in = 1'b0;
            end
         end else if ((found_ff != active_valid_ff) ||
                      (found_ff && (pick_ff != active_idx_ff))) begin
            rsp_changed_in  = 1'b1;
            rsp_fan_in      = found_ff ? pick_mode_ff : default_mode_ff;
            active_valid_in = found_ff;
            active_idx_in   = pick_ff;
         end
         rsp_active_in = active_valid_in ? ACTIVE_W'(active_idx_in) : ACTIVE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff       <= '0;
         active_valid_ff <= 1'b0;
         default_mode_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (table_we) begin
            enable_ff[wr_idx] <= wr_enable_ff;
         end
         active_valid_ff <= active_valid_in;
         default_mode_ff <= default_mode_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (table_we) begin
         table_ff[wr_idx] <= wr_entry_ff;
      end
      if (cmd.capture) begin
         action_ff                 <= req_tuser;
         slot_ff                   <= req_tdata[3:0];
         wr_enable_ff              <= req_tdata[4];
         wr_entry_ff.start_hour    <= req_tdata[9:5];
         wr_entry_ff.start_minute  <= req_tdata[15:10];
         wr_entry_ff.end_hour      <= req_tdata[20:16];
         wr_entry_ff.end_minute    <= req_tdata[26:21];
         wr_entry_ff.mode_value    <= req_tdata[30:27];
         wr_entry_ff.day_mask      <= req_tdata[37:31];
         // hour above minute so the key orders by hour first
         now_key_ff                <= {req_tdata[42:38], req_tdata[48:43]};
         now_wd_ff                 <= req_tdata[51:49];
      end
      scan_idx_ff    <= scan_idx_in;
      found_ff       <= found_in;
      pick_ff        <= pick_in;
      pick_mode_ff   <= pick_mode_in;
      active_idx_ff  <= active_idx_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_fan_ff     <= rsp_fan_in;
      rsp_active_ff  <= rsp_active_in;
      rsp_werr_ff    <= rsp_werr_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_werr_ff, rsp_active_ff, rsp_fan_ff, rsp_changed_ff};

   // A result is loaded only into a free result register.
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

   // A committed result is presented on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed result not presented");

   // A write result never reports a mode change.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (action_ff == ACTION_WRITE)) |=> !rsp_changed_ff)
      else $error("write reported a mode change");

endmodule
`default_nettype wire

@@ hw/rtl/wtps_controller.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wtps_controller
// Sequencer: accept a request, scan the table one slot a cycle for a check, commit.
// ----------------------------------------------------------------------------
module wtps_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire wtps_pkg::status_type status,
   output wtps_pkg::cmd_type         cmd
);
   import wtps_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      cmd.capture   = 1'b0;
      cmd.scan_step = 1'b0;
      cmd.commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.is_write) begin
               state_in = ST_FINISH;
            end else begin
               cmd.scan_step = 1'b1;
               if (status.scan_hit || status.scan_last) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the finished item while the result register is occupied.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !status.out_free) |=> (state_ff == ST_FINISH))
      else $error("finished item dropped while stalled");

   // Every accepted request moves on to the scan state.
   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_SCAN))
      else $error("accepted request not processed");

   // Scan stops on a hit.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step && status.scan_hit) |=> (state_ff == ST_FINISH))
      else $error("scan continued past a hit");

endmodule
`default_nettype wire

@@ hw/rtl/weekly_time_program_selector.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// weekly_time_program_selector
// Weekly table of fan time programs; picks the first matching program on a
// time check and reports changes of the active program.
// ----------------------------------------------------------------------------
//  channel   direction  transfer when            carries
//  req_*     in         req_tvalid & req_tready   one write or check item
//  rsp_*     out        rsp_tvalid & rsp_tready   one result per item
//  csr_*     in         csr_valid & csr_ready     default fan mode
//
//  A write goes from capture straight to commit; a check first tests the slots,
//  one per cycle, lowest first, stopping on a hit (1 to 16 slots tested); the
//  result register is loaded at commit and req_tready returns only after it,
//  so no new item is taken before the last one is committed.
//  A busy result register holds the item until rsp_tready frees it.
//  Reset clears every enable bit, the active program and the default mode.
// ----------------------------------------------------------------------------
module weekly_time_program_selector (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // req_tuser: action (0 = check, 1 = write)
   // req_tdata from bit 0: slot[4], enable[1], start_hour[5], start_minute[6],
   //   end_hour[5], end_minute[6], mode_value[4], day_mask[7], now_hour[5],
   //   now_minute[6], now_weekday[3], zero pad[4]
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic                            req_tuser,
   input  wire logic [wtps_pkg::REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata from bit 0: mode_changed[1], fan_mode[4], active_slot[5],
   //   write_error[1], zero pad[5]
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [wtps_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // csr_wdata: default_mode
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [wtps_pkg::MODE_W-1:0]     csr_wdata
);
   import wtps_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequence each item: capture, scan, commit
   wtps_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Hold the table, active program and result register
   wtps_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire
